### hw/rtl/ir_carrier_uart_transmitter_top_defines.svh
// Assertion macros for the IR carrier UART transmitter RTL.
`ifndef IR_CARRIER_UART_TRANSMITTER_TOP_DEFINES_SVH
`define IR_CARRIER_UART_TRANSMITTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define IRCUT_ASSERT_IMPLIES(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define IRCUT_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define IRCUT_ASSERT_IMPLIES(label, clk, rstn, cond, expr)
`define IRCUT_ASSERT_NEXT(label, clk, rstn, cond, expr)
`endif

`endif

### hw/rtl/ircut_pkg.sv
// Package with types and constants for the IR carrier UART transmitter.
package ircut_pkg;

    localparam int unsigned HALF_PERIOD_W   = 16;
    localparam int unsigned CYCLES_W        = 8;
    localparam int unsigned HALF_INDEX_W    = 9;
    localparam int unsigned BIT_POS_W       = 4;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned CFG_DATA_W      = 16;
    localparam int unsigned OUT_TDATA_W     = 8;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd13;
    localparam logic [CYCLES_W-1:0]      CYCLES_RESET      = 8'd16;

    // Frame layout: start bit at position 0, stop bit at STOP_POS.
    localparam logic [BIT_POS_W-1:0] STOP_POS   = 4'd9;
    localparam logic [BIT_POS_W-1:0] FRAME_BITS = 4'd10;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_HALF_PERIOD = 1'b0,
        CFG_CYCLES      = 1'b1
    } cfg_index_t;

    // Input operation codes carried in tuser.
    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_SEND = 1'b1
    } op_t;

    // Live configuration handed from the register block to the core.
    typedef struct packed {
        logic [HALF_PERIOD_W-1:0] half_period_ticks;
        logic [CYCLES_W-1:0]      carrier_cycles_per_bit;
    } cfg_t;

endpackage

### hw/rtl/ircut_cfg.sv
// Configuration register block for the IR carrier UART transmitter.
module ircut_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [0:0]                        cfg_index,
    input  logic [ircut_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output ircut_pkg::cfg_t                   cfg
);

    logic [ircut_pkg::HALF_PERIOD_W-1:0] half_period_reg;
    logic [ircut_pkg::CYCLES_W-1:0]      cycles_reg;

    // Register writes; the lower bits of the write data are kept.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= ircut_pkg::HALF_PERIOD_RESET;
            cycles_reg      <= ircut_pkg::CYCLES_RESET;
        end else if (cfg_we) begin
            case (ircut_pkg::cfg_index_t'(cfg_index))
                ircut_pkg::CFG_HALF_PERIOD: begin
                    half_period_reg <= cfg_wdata[ircut_pkg::HALF_PERIOD_W-1:0];
                end
                ircut_pkg::CFG_CYCLES: begin
                    cycles_reg <= cfg_wdata[ircut_pkg::CYCLES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.half_period_ticks      = half_period_reg;
    assign cfg.carrier_cycles_per_bit = cycles_reg;

endmodule

### hw/rtl/ircut_core.sv
// Frame sequencer and result register of the IR carrier UART transmitter.
`include "ir_carrier_uart_transmitter_top_defines.svh"

module ircut_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ircut_pkg::cfg_t                      cfg,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ircut_pkg::BYTE_W-1:0]         s_tdata,
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ircut_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int unsigned HPW = ircut_pkg::HALF_PERIOD_W;
    localparam int unsigned HIW = ircut_pkg::HALF_INDEX_W;
    localparam int unsigned BPW = ircut_pkg::BIT_POS_W;

    // Frame state.
    logic [ircut_pkg::BYTE_W-1:0] shift_reg, shift_next;
    logic [BPW-1:0]               pos_reg, pos_next;
    logic [HPW-1:0]               tick_reg, tick_next;
    logic [HIW-1:0]               half_reg, half_next;
    logic                         sending_reg, sending_next;

    // Result register.
    logic out_valid_reg, out_valid_next;
    logic res_level_reg, res_level_next;
    logic res_busy_reg, res_busy_next;
    logic res_rej_reg, res_rej_next;
    logic res_done_reg, res_done_next;

    logic                 accept;
    logic [HPW-1:0]       hp;
    logic [HIW-1:0]       halves;
    logic                 bit_value;
    logic [HPW:0]         tick_inc;
    logic [HIW:0]         half_inc;
    logic [BPW-1:0]       pos_inc;
    logic [2:0]           data_sel;
    logic                 half_wrap;
    logic                 bit_wrap;
    logic                 frame_end;

    // A new transaction enters whenever the result register is empty or draining.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Effective limits: a zero register acts as one.
    assign hp = (cfg.half_period_ticks == '0) ? HPW'(1) : cfg.half_period_ticks;
    assign halves = (cfg.carrier_cycles_per_bit == '0) ? HIW'(2)
                  : {cfg.carrier_cycles_per_bit, 1'b0};

    // Value of the frame bit in progress.
    assign data_sel = 3'(pos_reg - BPW'(1));
    always_comb begin
        if (pos_reg == '0) begin
            bit_value = 1'b0;
        end else if (pos_reg >= ircut_pkg::STOP_POS) begin
            bit_value = 1'b1;
        end else begin
            bit_value = shift_reg[data_sel];
        end
    end

    // Counter increments and rollover conditions.
    assign tick_inc  = {1'b0, tick_reg} + (HPW+1)'(1);
    assign half_inc  = {1'b0, half_reg} + (HIW+1)'(1);
    assign pos_inc   = pos_reg + BPW'(1);
    assign half_wrap = (tick_inc[HPW-1:0] == '0) || (tick_inc[HPW-1:0] >= hp);
    assign bit_wrap  = (half_inc[HIW-1:0] == '0) || (half_inc[HIW-1:0] >= halves);
    assign frame_end = (pos_inc >= ircut_pkg::FRAME_BITS) || (pos_inc == '0);

    // Next state and result for the accepted transaction.
    always_comb begin
        shift_next     = shift_reg;
        pos_next       = pos_reg;
        tick_next      = tick_reg;
        half_next      = half_reg;
        sending_next   = sending_reg;
        res_level_next = res_level_reg;
        res_busy_next  = res_busy_reg;
        res_rej_next   = res_rej_reg;
        res_done_next  = res_done_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (accept) begin
            out_valid_next = 1'b1;
            res_level_next = 1'b0;
            res_rej_next   = 1'b0;
            res_done_next  = 1'b0;
            case (ircut_pkg::op_t'(s_tuser))
                ircut_pkg::OP_SEND: begin
                    if (sending_reg) begin
                        res_rej_next = 1'b1;
                    end else begin
                        shift_next   = s_tdata;
                        pos_next     = '0;
                        tick_next    = '0;
                        half_next    = '0;
                        sending_next = 1'b1;
                    end
                end
                ircut_pkg::OP_TICK: begin
                    if (sending_reg) begin
                        res_level_next = !bit_value && !half_reg[0];
                        tick_next      = tick_inc[HPW-1:0];
                        if (half_wrap) begin
                            tick_next = '0;
                            half_next = half_inc[HIW-1:0];
                            if (bit_wrap) begin
                                half_next = '0;
                                pos_next  = pos_inc;
                                if (frame_end) begin
                                    pos_next      = '0;
                                    sending_next  = 1'b0;
                                    res_done_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            res_busy_next = sending_next;
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            tick_reg      <= '0;
            half_reg      <= '0;
            shift_reg     <= '0;
        end else begin
            sending_reg   <= sending_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            tick_reg      <= tick_next;
            half_reg      <= half_next;
            shift_reg     <= shift_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        res_level_reg <= res_level_next;
        res_busy_reg  <= res_busy_next;
        res_rej_reg   <= res_rej_next;
        res_done_reg  <= res_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, res_done_reg, res_rej_reg, res_busy_reg, res_level_reg};

    // A finished frame leaves the block idle, and a rejected send means a frame runs.
    `IRCUT_ASSERT_IMPLIES(a_done_idle, aclk, aresetn, m_tvalid && res_done_reg, !res_busy_reg)
    `IRCUT_ASSERT_IMPLIES(a_rej_busy, aclk, aresetn, m_tvalid && res_rej_reg, res_busy_reg)
    // The carrier is only driven while a frame is still running.
    `IRCUT_ASSERT_IMPLIES(a_level_busy, aclk, aresetn, m_tvalid && res_level_reg, res_busy_reg)
    // A frame ends only through its stop bit, which is reported as done.
    `IRCUT_ASSERT_NEXT(a_end_done, aclk, aresetn, sending_reg && !sending_next, res_done_reg)

endmodule

### hw/rtl/ir_carrier_uart_transmitter_top.sv
// Top level of the IR carrier-modulated 8N1 UART transmitter.
//
//  Channel | Direction | Payload
//  s_      | in        | tdata[7:0] data_byte, tuser[0] op (0 tick, 1 send)
//  m_      | out       | tdata[0] ir_level, [1] busy_res, [2] rejected, [3] byte_done
//  cfg_    | in        | index 0 half_period_ticks, index 1 carrier_cycles_per_bit
//
// Every transaction yields one result, registered in the cycle after it is accepted.
// The frame counters update in one pass, and a new transaction is accepted every
// cycle except while the result register holds a stalled result not yet draining.
// aresetn is synchronous; reset leaves the block idle with default settings.
module ir_carrier_uart_transmitter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] ir_level, [1] busy_res, [2] rejected,
                                    // [3] byte_done, [7:4] zero
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    ircut_pkg::cfg_t cfg;

    // Configuration registers.
    ircut_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Frame sequencer with result register.
    ircut_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### tb/ir_carrier_uart_transmitter_top_tb.sv
// Self-checking testbench for the IR carrier-modulated 8N1 UART transmitter.
module ir_carrier_uart_transmitter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned PHASE_ITEMS    = 150;

    // Status bits of one result, most significant field first.
    typedef struct packed {
        logic byte_done;
        logic rejected;
        logic busy;
        logic ir_level;
    } tx_status_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tuser;    // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;    // [0] ir_level, [1] busy_res, [2] rejected, [3] byte_done
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_wdata;

    // Transmitter state as the checker sees it.
    logic [15:0] half_period_reg;
    logic [7:0]  cycles_reg;
    logic [7:0]  frame_byte;
    logic [3:0]  frame_pos;
    logic [15:0] half_ticks;
    logic [8:0]  half_count;
    logic        in_frame;

    tx_status_t  expected_status_q[$];
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;

    ir_carrier_uart_transmitter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Computes the status of one transaction and advances the frame state.
    function automatic tx_status_t advance_transmitter(input ircut_pkg::op_t op,
                                                       input logic [7:0] data);
        tx_status_t  st;
        int unsigned half_limit;
        int unsigned halves;
        logic        line_bit;
        st = '0;
        if (op == ircut_pkg::OP_SEND) begin
            if (in_frame) begin
                st.rejected = 1'b1;
            end else begin
                frame_byte = data;
                frame_pos  = '0;
                half_ticks = '0;
                half_count = '0;
                in_frame   = 1'b1;
            end
        end else if (in_frame) begin
            half_limit = (half_period_reg == 0) ? 1 : half_period_reg;
            halves     = 2 * ((cycles_reg == 0) ? 1 : cycles_reg);
            if (frame_pos == 0)
                line_bit = 1'b0;
            else if (frame_pos >= ircut_pkg::STOP_POS)
                line_bit = 1'b1;
            else
                line_bit = frame_byte[3'(frame_pos - 4'd1)];
            // A zero bit carries the carrier: high in even half periods.
            st.ir_level = !line_bit && !half_count[0];
            half_ticks = half_ticks + 16'd1;
            if (half_ticks == 0 || half_ticks >= half_limit) begin
                half_ticks = '0;
                half_count = half_count + 9'd1;
                if (half_count == 0 || half_count >= halves) begin
                    half_count = '0;
                    frame_pos  = frame_pos + 4'd1;
                    if (frame_pos >= ircut_pkg::FRAME_BITS || frame_pos == 0) begin
                        frame_pos    = '0;
                        in_frame     = 1'b0;
                        st.byte_done = 1'b1;
                    end
                end
            end
        end
        st.busy = in_frame;
        return st;
    endfunction

    // Checks results, then records register writes and accepted transactions.
    always @(posedge aclk) begin
        tx_status_t got;
        tx_status_t want;
        if (!aresetn) begin
            half_period_reg = ircut_pkg::HALF_PERIOD_RESET;
            cycles_reg      = ircut_pkg::CYCLES_RESET;
            frame_byte      = '0;
            frame_pos       = '0;
            half_ticks      = '0;
            half_count      = '0;
            in_frame        = 1'b0;
            quiet_cycles    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = tx_status_t'(m_tdata[3:0]);
                if (expected_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result %b", $realtime, m_tdata);
                end else begin
                    want = expected_status_q.pop_front();
                    if (got.ir_level !== want.ir_level || got.busy !== want.busy ||
                        got.rejected !== want.rejected || got.byte_done !== want.byte_done) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: expected level %b busy %b rejected %b done %b,",
                                      " got %b %b %b %b"},
                                     $realtime, want.ir_level, want.busy, want.rejected,
                                     want.byte_done, got.ir_level, got.busy, got.rejected,
                                     got.byte_done);
                    end
                end
            end
            if (cfg_we) begin
                case (ircut_pkg::cfg_index_t'(cfg_index))
                    ircut_pkg::CFG_HALF_PERIOD: half_period_reg = cfg_wdata;
                    ircut_pkg::CFG_CYCLES:      cycles_reg      = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_status_q.push_back(
                    advance_transmitter(ircut_pkg::op_t'(s_tuser), s_tdata));

            // Watchdog on cycles with no transaction on either channel.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("ir_carrier_uart_transmitter_top_tb NOT OK");
                $finish;
            end
        end
    end

    // Result channel back-pressure.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Optional sender gap, ending at the falling edge where the next item is driven.
    task automatic wait_slot();
        int unsigned gap;
        gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 4) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
    endtask

    // Presents one item and returns at the edge where it is accepted.
    task automatic present(input ircut_pkg::op_t op, input logic [7:0] data);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_item(input ircut_pkg::op_t op, input logic [7:0] data);
        wait_slot();
        present(op, data);
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_item(ircut_pkg::OP_TICK, 8'($urandom));
    endtask

    // Lets the input channel go quiet and all results drain.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_status_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_register(input ircut_pkg::cfg_index_t idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // Idle ticks, a frame start and a send rejected while busy, at reset settings.
    task automatic test_reset_settings();
        send_item(ircut_pkg::OP_TICK, 8'hFF);
        send_item(ircut_pkg::OP_SEND, 8'hFF);
        send_item(ircut_pkg::OP_SEND, 8'h00);
        send_ticks(3);
        wait_idle();
    endtask

    // Largest settings written in the middle of a frame.
    task automatic test_max_settings();
        write_register(ircut_pkg::CFG_HALF_PERIOD, 16'hFFFF);
        write_register(ircut_pkg::CFG_CYCLES, 16'h00FF);
        send_ticks(3);
        wait_idle();
    endtask

    // Zero settings act as one; the counters already past the new limits roll over.
    task automatic test_zero_settings();
        write_register(ircut_pkg::CFG_HALF_PERIOD, 16'h0000);
        write_register(ircut_pkg::CFG_CYCLES, 16'h0000);
        send_ticks(21);
        wait_idle();
    endtask

    // Random frames with small settings under one idling profile.
    task automatic test_random_frames(input int unsigned idle_pct, input int unsigned stall_pct);
        logic [7:0] byte_val;
        logic       start;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        write_register(ircut_pkg::CFG_HALF_PERIOD, 16'($urandom_range(0, 3)));
        write_register(ircut_pkg::CFG_CYCLES, {8'($urandom), 8'($urandom_range(0, 2))});
        repeat (PHASE_ITEMS) begin
            wait_slot();
            // Mostly start frames when idle; a few sends land on a busy transmitter.
            byte_val = 8'($urandom);
            if (in_frame)
                start = ($urandom_range(99) < 3);
            else
                start = ($urandom_range(99) < 70);
            present(start ? ircut_pkg::OP_SEND : ircut_pkg::OP_TICK, byte_val);
        end
        wait_idle();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ircut_pkg::OP_TICK;
        cfg_we         = 1'b0;
        cfg_index      = ircut_pkg::CFG_HALF_PERIOD;
        cfg_wdata      = '0;
        mismatches     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_settings();
        test_max_settings();
        test_zero_settings();
        test_random_frames(0, 0);
        test_random_frames(59, 0);
        test_random_frames(0, 59);
        test_random_frames(20, 20);

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_status_q.size() == 0)
            $display("ir_carrier_uart_transmitter_top_tb OK");
        else
            $display("ir_carrier_uart_transmitter_top_tb NOT OK");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ircut_pkg.sv
hw/rtl/ircut_cfg.sv
hw/rtl/ircut_core.sv
hw/rtl/ir_carrier_uart_transmitter_top.sv
tb/ir_carrier_uart_transmitter_top_tb.sv
